// ----- sv/assert_macros.svh -----
// Assertion macros shared by the go-to-goal velocity pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GVC_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("goal velocity pipeline assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GVC_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("goal velocity pipeline assertion failed");

`endif

// ----- sv/gvc_pkg.sv -----
// Shared types, widths and constants of the go-to-goal velocity pipeline.
package gvc_pkg;

	localparam int CW    = 32;          // pose and velocity width
	localparam int DW    = CW + 1;      // signed gap width
	localparam int MW    = DW;          // gap magnitude width
	localparam int POSW  = $clog2(MW);  // width of a bit position in a magnitude
	localparam int NW    = 31;          // normalized magnitude width
	localparam int NORM_MSB = NW - 1;   // top bit of a normalized magnitude
	localparam int REGW  = 31;          // configuration register width
	localparam int CFGDW = 32;          // configuration data port width
	localparam int PW    = REGW + NW;   // product width
	localparam int SQW   = 64;          // sum of squares width
	localparam int RW    = SQW / 2;     // square root width
	localparam int REMW  = RW + 3;      // square root remainder width
	localparam int QW    = 31;          // quotient width
	localparam int LANES = 3;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [REGW-1:0] reg_t;
	typedef logic [PW-1:0] prod_t;

	typedef enum logic [2:0] {
		REG_CRUISE  = 3'd0,
		REG_TOL     = 3'd1,
		REG_MAX_LIN = 3'd2,
		REG_MIN_LIN = 3'd3,
		REG_MAX_ANG = 3'd4,
		REG_MIN_ANG = 3'd5
	} reg_idx_t;

	localparam reg_t CRUISE_RST  = REGW'(1966080);
	localparam reg_t TOL_RST     = REGW'(13107);
	localparam reg_t MAX_LIN_RST = REGW'(1966080);
	localparam reg_t MIN_LIN_RST = REGW'(0);
	localparam reg_t MAX_ANG_RST = REGW'(823550);
	localparam reg_t MIN_ANG_RST = REGW'(12868);

	typedef struct packed {
		reg_t cruise;
		reg_t tol;
		reg_t max_lin;
		reg_t min_lin;
		reg_t max_ang;
		reg_t min_ang;
	} cfg_t;

	// Per-item data that rides along the square root stages.
	typedef struct packed {
		logic far;
		logic [LANES-1:0] neg;
		prod_t [LANES-1:0] prod;
	} side_t;

	function automatic logic [POSW-1:0] msb_pos(input logic [MW-1:0] v);
		logic [POSW-1:0] p;
		p = '0;
		for (int i = 0; i < MW; i++) begin
			if (v[i]) begin
				p = POSW'(i);
			end
		end
		return p;
	endfunction

endpackage

// ----- sv/gvc_front.sv -----
// Front stages: pose gaps, reach test, normalization, squares and speed products.
module gvc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  gvc_pkg::coord_t robot_x,
	input  gvc_pkg::coord_t robot_y,
	input  gvc_pkg::coord_t robot_heading,
	input  gvc_pkg::coord_t target_x,
	input  gvc_pkg::coord_t target_y,
	input  gvc_pkg::coord_t target_heading,
	input  gvc_pkg::cfg_t  cfg,
	output logic           out_vld,
	output logic [gvc_pkg::SQW-1:0] sumsq,
	output gvc_pkg::side_t side
);
	import gvc_pkg::*;

	logic signed [DW-1:0] gap [LANES];
	logic [MW-1:0] mag [LANES];
	logic [MW-1:0] big;

	logic [4:0] vld_s;
	logic [MW-1:0] mag_s1 [LANES];
	logic [MW-1:0] big_s1;
	logic [LANES-1:0] neg_s1, neg_s2, neg_s3, neg_s4;
	logic far_s1, far_s2, far_s3, far_s4;
	logic [MW-1:0] mag_s2 [LANES];
	logic [POSW-1:0] pos_s2;
	logic [NW-1:0] mn_s3 [LANES];
	logic [PW-1:0] sq_s4 [LANES];
	prod_t [LANES-1:0] prod_s4;
	logic [SQW-1:0] sum_s5;
	side_t side_s5;

	always_comb begin
		gap[0] = DW'(target_x) - DW'(robot_x);
		gap[1] = DW'(target_y) - DW'(robot_y);
		gap[2] = DW'(target_heading) - DW'(robot_heading);
		for (int i = 0; i < LANES; i++) begin
			mag[i] = gap[i][DW-1] ? MW'(-gap[i]) : MW'(gap[i]);
		end
		big = (mag[1] > mag[0]) ? mag[1] : mag[0];
		if (mag[2] > big) begin
			big = mag[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: gaps and the reach test.
			for (int i = 0; i < LANES; i++) begin
				mag_s1[i] <= mag[i];
				neg_s1[i] <= gap[i][DW-1];
			end
			big_s1 <= big;
			far_s1 <= (mag[0] > MW'(cfg.tol)) || (mag[1] > MW'(cfg.tol));

			// Stage 2: position of the leading one of the largest gap.
			mag_s2 <= mag_s1;
			pos_s2 <= msb_pos(big_s1);
			neg_s2 <= neg_s1;
			far_s2 <= far_s1;

			// Stage 3: shift all gaps together so the largest lands on the top bit.
			for (int i = 0; i < LANES; i++) begin
				if (pos_s2 <= POSW'(NORM_MSB)) begin
					mn_s3[i] <= NW'(mag_s2[i] << (POSW'(NORM_MSB) - pos_s2));
				end else begin
					mn_s3[i] <= NW'(mag_s2[i] >> (pos_s2 - POSW'(NORM_MSB)));
				end
			end
			neg_s3 <= neg_s2;
			far_s3 <= far_s2;

			// Stage 4: squares and cruise speed products.
			for (int i = 0; i < LANES; i++) begin
				sq_s4[i]   <= PW'(mn_s3[i]) * PW'(mn_s3[i]);
				prod_s4[i] <= PW'(cfg.cruise) * PW'(mn_s3[i]);
			end
			neg_s4 <= neg_s3;
			far_s4 <= far_s3;

			// Stage 5: sum of squares.
			sum_s5 <= SQW'(sq_s4[0]) + SQW'(sq_s4[1]) + SQW'(sq_s4[2]);
			side_s5.far  <= far_s4;
			side_s5.neg  <= neg_s4;
			side_s5.prod <= prod_s4;
		end
	end

	assign out_vld = vld_s[4];
	assign sumsq   = sum_s5;
	assign side    = side_s5;

endmodule

// ----- sv/gvc_sqrt.sv -----
// Square root pipeline: one root bit per stage.
`include "assert_macros.svh"
module gvc_sqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [gvc_pkg::SQW-1:0] sumsq,
	input  gvc_pkg::side_t in_side,
	output logic           out_vld,
	output logic [gvc_pkg::RW-1:0] root,
	output gvc_pkg::side_t out_side
);
	import gvc_pkg::*;

	logic [RW-1:0] vld_s;
	logic [SQW-1:0] x_s [RW];
	logic [REMW-1:0] rem_s [RW];
	logic [RW-1:0] root_s [RW];
	side_t side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic vld_in;
		logic [SQW-1:0] x_in;
		logic [REMW-1:0] rem_in, rem_sh, trial;
		logic [RW-1:0] root_in;
		side_t side_in;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign x_in    = sumsq;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign x_in    = x_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign rem_sh = {rem_in[REMW-3:0], x_in[2*(RW-1-k)+1 -: 2]};
		assign trial  = REMW'({root_in, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= x_in;
				side_s[k] <= side_in;
				if (rem_sh >= trial) begin
					rem_s[k]  <= rem_sh - trial;
					root_s[k] <= {root_in[RW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_sh;
					root_s[k] <= {root_in[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign root     = root_s[RW-1];
	assign out_side = side_s[RW-1];

	// A far item has its largest gap normalized to the top bit, so its root is never small.
	`GVC_ASSERT_IMP(a_root_norm, out_vld && out_side.far, root[RW-1:RW-2] != 2'b00)

endmodule

// ----- sv/gvc_div.sv -----
// Divider pipeline: three lanes of product over root, one quotient bit per stage.
module gvc_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [gvc_pkg::RW-1:0] root,
	input  gvc_pkg::side_t in_side,
	output logic           out_vld,
	output logic [gvc_pkg::LANES-1:0][gvc_pkg::QW-1:0] quot,
	output logic           out_far,
	output logic [gvc_pkg::LANES-1:0] out_neg
);
	import gvc_pkg::*;

	logic [QW-1:0] vld_s;
	logic [RW-1:0] n_s [QW];
	logic far_s [QW];
	logic [LANES-1:0] neg_s [QW];
	logic [RW-1:0] rem_s [QW][LANES];
	logic [QW-1:0] q_s [QW][LANES];
	prod_t prod_s [QW][LANES];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic vld_in, far_in;
		logic [RW-1:0] n_in;
		logic [LANES-1:0] neg_in;

		if (k == 0) begin : g_first
			assign vld_in = in_vld;
			assign n_in   = root;
			assign far_in = in_side.far;
			assign neg_in = in_side.neg;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign n_in   = n_s[k-1];
			assign far_in = far_s[k-1];
			assign neg_in = neg_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k]   <= n_in;
				far_s[k] <= far_in;
				neg_s[k] <= neg_in;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [RW-1:0] rem_in;
			logic [QW-1:0] q_in;
			prod_t prod_in;
			logic [RW:0] rem_sh;
			logic ge;

			if (k == 0) begin : g_first
				// The quotient fits in QW bits, so the top bits start below the divisor.
				assign prod_in = in_side.prod[l];
				assign rem_in  = RW'(in_side.prod[l][PW-1:QW]);
				assign q_in    = '0;
			end else begin : g_next
				assign prod_in = prod_s[k-1][l];
				assign rem_in  = rem_s[k-1][l];
				assign q_in    = q_s[k-1][l];
			end

			assign rem_sh = {rem_in, prod_in[QW-1-k]};
			assign ge     = rem_sh >= {1'b0, n_in};

			always_ff @(posedge clk) begin
				if (en) begin
					prod_s[k][l] <= prod_in;
					rem_s[k][l]  <= ge ? RW'(rem_sh - {1'b0, n_in}) : RW'(rem_sh);
					q_s[k][l]    <= {q_in[QW-2:0], ge};
				end
			end
		end
	end

	assign out_vld = vld_s[QW-1];
	assign out_far = far_s[QW-1];
	assign out_neg = neg_s[QW-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quot[l] = q_s[QW-1][l];
	end

endmodule

// ----- sv/gvc_bound.sv -----
// Output stage: limit each velocity component and hold the finished item.
`include "assert_macros.svh"
module gvc_bound (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld,
	input  logic [gvc_pkg::LANES-1:0][gvc_pkg::QW-1:0] quot,
	input  logic           far,
	input  logic [gvc_pkg::LANES-1:0] neg,
	input  gvc_pkg::cfg_t  cfg,
	output logic           out_vld,
	output logic [gvc_pkg::LANES-1:0][gvc_pkg::CW-1:0] vel,
	output logic           goal_reached
);
	import gvc_pkg::*;

	logic vld_q;
	logic done_q;
	logic [LANES-1:0][CW-1:0] vel_q;
	logic [LANES-1:0][CW-1:0] vel_d;

	// Clamp the magnitude to hi, then raise a small nonzero one to lo.
	function automatic logic [QW-1:0] limit(input logic [QW-1:0] q, input reg_t hi,
		input reg_t lo);
		logic [QW-1:0] a;
		a = (q > QW'(hi)) ? QW'(hi) : q;
		if (a != '0 && a < QW'(lo)) begin
			a = QW'(lo);
		end
		return a;
	endfunction

	always_comb begin
		logic [QW-1:0] m;
		for (int i = 0; i < LANES; i++) begin
			if (i == LANES - 1) begin
				m = limit(quot[i], cfg.max_ang, cfg.min_ang);
			end else begin
				m = limit(quot[i], cfg.max_lin, cfg.min_lin);
			end
			if (!far) begin
				vel_d[i] = '0;
			end else if (neg[i]) begin
				vel_d[i] = -CW'(m);
			end else begin
				vel_d[i] = CW'(m);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vel_q  <= vel_d;
			done_q <= !far;
		end
	end

	assign out_vld      = vld_q;
	assign vel          = vel_q;
	assign goal_reached = done_q;

	`GVC_ASSERT_IMP(a_goal_zero, vld_q && done_q, vel_q == '0)
	`GVC_ASSERT_NXT(a_far_flag, en && vld && far, out_vld && !goal_reached)

endmodule

// ----- sv/goal_velocity_command.sv -----
// Go-to-goal velocity command: pose pair in, bounded velocity vector out.
//
// Pose channel (pose_valid/pose_stall) carries robot and target poses in
// signed Q16.16. The velocity channel (vel_valid/vel_stall) returns one item
// per pose item: vel_x, vel_y, vel_turn and goal_reached, in order.
// Configuration registers are written over cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write them only while
// the pipeline holds no item.
// From acceptance to vel_valid an item passes five front stages, 32
// square root stages (one root bit each), 31 divider stages (one quotient
// bit each) and the output register. Throughput is one item per clock
// when not stalled; every stage is a plain register with a valid bit.
// Reset clears all valid bits and loads the register defaults.
// When the output item is stalled the whole pipeline holds, bubbles
// included, and pose_stall rises.
`include "assert_macros.svh"
module goal_velocity_command (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pose_valid,
	output logic           pose_stall,
	input  gvc_pkg::coord_t robot_x,
	input  gvc_pkg::coord_t robot_y,
	input  gvc_pkg::coord_t robot_heading,
	input  gvc_pkg::coord_t target_x,
	input  gvc_pkg::coord_t target_y,
	input  gvc_pkg::coord_t target_heading,
	output logic           vel_valid,
	input  logic           vel_stall,
	output gvc_pkg::coord_t vel_x,
	output gvc_pkg::coord_t vel_y,
	output gvc_pkg::coord_t vel_turn,
	output logic           goal_reached,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [gvc_pkg::CFGDW-1:0] cfg_data
);
	import gvc_pkg::*;

	cfg_t cfg_q;
	logic en;
	logic front_vld, sqrt_vld, div_vld;
	logic [SQW-1:0] sumsq;
	side_t front_side, sqrt_side;
	logic [RW-1:0] root;
	logic [LANES-1:0][QW-1:0] quot;
	logic div_far;
	logic [LANES-1:0] div_neg;
	logic [LANES-1:0][CW-1:0] vel;

	assign cfg_ready  = 1'b1;
	assign en         = !(vel_valid && vel_stall);
	assign pose_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cruise  <= CRUISE_RST;
			cfg_q.tol     <= TOL_RST;
			cfg_q.max_lin <= MAX_LIN_RST;
			cfg_q.min_lin <= MIN_LIN_RST;
			cfg_q.max_ang <= MAX_ANG_RST;
			cfg_q.min_ang <= MIN_ANG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CRUISE:  cfg_q.cruise  <= cfg_data[REGW-1:0];
				REG_TOL:     cfg_q.tol     <= cfg_data[REGW-1:0];
				REG_MAX_LIN: cfg_q.max_lin <= cfg_data[REGW-1:0];
				REG_MIN_LIN: cfg_q.min_lin <= cfg_data[REGW-1:0];
				REG_MAX_ANG: cfg_q.max_ang <= cfg_data[REGW-1:0];
				REG_MIN_ANG: cfg_q.min_ang <= cfg_data[REGW-1:0];
				default: ;
			endcase
		end
	end

	gvc_front u_front (
		.clk, .arst_n, .en,
		.in_vld(pose_valid && en),
		.robot_x, .robot_y, .robot_heading,
		.target_x, .target_y, .target_heading,
		.cfg(cfg_q),
		.out_vld(front_vld),
		.sumsq,
		.side(front_side)
	);

	gvc_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_vld(front_vld),
		.sumsq,
		.in_side(front_side),
		.out_vld(sqrt_vld),
		.root,
		.out_side(sqrt_side)
	);

	gvc_div u_div (
		.clk, .arst_n, .en,
		.in_vld(sqrt_vld),
		.root,
		.in_side(sqrt_side),
		.out_vld(div_vld),
		.quot,
		.out_far(div_far),
		.out_neg(div_neg)
	);

	gvc_bound u_bound (
		.clk, .arst_n, .en,
		.vld(div_vld),
		.quot,
		.far(div_far),
		.neg(div_neg),
		.cfg(cfg_q),
		.out_vld(vel_valid),
		.vel,
		.goal_reached
	);

	assign vel_x    = vel[0];
	assign vel_y    = vel[1];
	assign vel_turn = vel[2];

	`GVC_ASSERT_IMP(a_hold_on_stall, vel_valid && vel_stall, pose_stall)

endmodule
